// File: rtl/core/oat_pkg.sv
// Package for the oriented box against axis-aligned box overlap test.
// Holds field widths, payload types and the function that builds the quarter-wave sine table.
// No dependencies.
package oat_pkg;

  localparam int ANGLE_BITS     = 12;
  localparam int COORD_BITS     = 20;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int SIZE_BITS      = COORD_BITS - 1;
  localparam int QSIZE          = 1 << (ANGLE_BITS - 2);
  localparam int ADDR_BITS      = ANGLE_BITS - 1;
  localparam int MAG_BITS       = TRIG_FRAC_BITS + 1;
  localparam int OFS_BITS       = COORD_BITS + 3;
  localparam int PROD_BITS      = OFS_BITS + MAG_BITS + 1;
  localparam int DIST_BITS      = PROD_BITS + 1;
  localparam int MPROD_BITS     = SIZE_BITS + MAG_BITS;
  localparam int RAD_BITS       = MPROD_BITS + 2;

  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam int              SERIES_TERMS = 12;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]         size_t;
  typedef logic [ANGLE_BITS-1:0]        angle_t;
  typedef logic [ADDR_BITS-1:0]         trig_addr_t;
  typedef logic [MAG_BITS-1:0]          trig_mag_t;
  typedef trig_mag_t                    sine_table_t [QSIZE+1];

  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    begin
      q   = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem  = rem - den;
          q[b] = 1'b1;
        end
      end
      return q;
    end
  endfunction

  function automatic trig_mag_t quarter_sine(input longint unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint          s;
    longint          r;
    longint unsigned div;
    begin
      x    = (k * HALF_PI_Q30) >> (ANGLE_BITS - 2);
      term = x;
      s    = 0;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        if (n[0] == 1'b1) begin
          s = s + longint'(term);
        end else begin
          s = s - longint'(term);
        end
        div  = longint'(2 * n) * longint'(2 * n + 1);
        term = (term * x) >> 30;
        term = udiv64((term * x) >> 30, div);
      end
      if (s < 0) begin
        s = 0;
      end
      r = (s + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
      if (r > (longint'(1) << TRIG_FRAC_BITS)) begin
        r = longint'(1) << TRIG_FRAC_BITS;
      end
      return MAG_BITS'(r);
    end
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t t;
    begin
      for (int k = 0; k <= QSIZE; k++) begin
        t[k] = quarter_sine(longint'(k));
      end
      return t;
    end
  endfunction

endpackage

// File: rtl/core/oat_query_if.sv
// Query channel: one oriented box and one axis-aligned box per item.
// Depends on oat_pkg.
interface oat_query_if
  import oat_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t box_center_x;
  coord_t box_center_y;
  size_t  box_half_x;
  size_t  box_half_y;
  angle_t box_angle;
  coord_t rect_left;
  coord_t rect_top;
  size_t  rect_width;
  size_t  rect_height;

  modport source (
    output valid, box_center_x, box_center_y, box_half_x, box_half_y, box_angle,
           rect_left, rect_top, rect_width, rect_height,
    input  ready
  );
  modport sink (
    input  valid, box_center_x, box_center_y, box_half_x, box_half_y, box_angle,
           rect_left, rect_top, rect_width, rect_height,
    output ready
  );
endinterface

// File: rtl/core/oat_result_if.sv
// Result channel: one overlap flag per item.
// No dependencies.
interface oat_result_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

// File: rtl/core/obb_aabb_overlap_test.sv
// Oriented box against axis-aligned box overlap test, separating-axis method.
// Depends on oat_pkg, oat_query_if and oat_result_if.
//
// Usage:
//   query  : valid/ready channel carrying one box pair per item.
//   result : valid/ready channel carrying one overlap flag per item, in order.
//   Touching boxes report overlap.
// Timing:
//   Four register stages: sine/cosine table read and centre offsets, the
//   twelve projection products, the projection sums, then the compare into
//   the output register. result.valid follows the accepted item through v1,
//   v2 and v3 into its own register, holding with the data under back-pressure.
//   One item is accepted every cycle while the result is not stalled; the
//   table read at two addresses and the product stage set that rate.
// Reset:
//   rst clears all stage valid bits; no results are pending afterwards.
// Back-pressure:
//   While result.valid is high and result.ready low the whole pipeline
//   holds and query.ready is low; nothing is dropped or repeated.
module obb_aabb_overlap_test
  import oat_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  oat_query_if.sink           query,
  oat_result_if.source        result
);

  localparam sine_table_t SINE_ROM = build_sine_table();
  localparam trig_addr_t  QADDR    = trig_addr_t'(QSIZE);

  logic en;
  logic v1, v2, v3;

  assign en          = !result.valid || result.ready;
  assign query.ready = en;

  // stage 1: table read, offsets
  logic [1:0]              sin_q, cos_q;
  logic [ADDR_BITS-2:0]    ang_i;
  trig_addr_t              sin_addr, cos_addr;
  logic signed [OFS_BITS-1:0] tx_next, ty_next;

  assign sin_q    = query.box_angle[ANGLE_BITS-1 -: 2];
  assign cos_q    = sin_q + 2'd1;
  assign ang_i    = query.box_angle[ANGLE_BITS-3:0];
  assign sin_addr = sin_q[0] ? (QADDR - {1'b0, ang_i}) : {1'b0, ang_i};
  assign cos_addr = cos_q[0] ? (QADDR - {1'b0, ang_i}) : {1'b0, ang_i};

  assign tx_next = (OFS_BITS'(query.rect_left) <<< 1)
                 + OFS_BITS'($signed({1'b0, query.rect_width}))
                 - (OFS_BITS'(query.box_center_x) <<< 1);
  assign ty_next = (OFS_BITS'(query.rect_top) <<< 1)
                 + OFS_BITS'($signed({1'b0, query.rect_height}))
                 - (OFS_BITS'(query.box_center_y) <<< 1);

  trig_mag_t                  s1_sm, s1_cm;
  logic                       s1_sneg, s1_cneg;
  logic signed [OFS_BITS-1:0] s1_tx, s1_ty;
  size_t                      s1_hx, s1_hy, s1_w, s1_h;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sm   <= SINE_ROM[sin_addr];
      s1_cm   <= SINE_ROM[cos_addr];
      s1_sneg <= sin_q[1];
      s1_cneg <= cos_q[1];
      s1_tx   <= tx_next;
      s1_ty   <= ty_next;
      s1_hx   <= query.box_half_x;
      s1_hy   <= query.box_half_y;
      s1_w    <= query.rect_width;
      s1_h    <= query.rect_height;
    end
  end

  // stage 2: products
  logic signed [MAG_BITS:0] sm_s, cm_s;
  assign sm_s = $signed({1'b0, s1_sm});
  assign cm_s = $signed({1'b0, s1_cm});

  logic signed [PROD_BITS-1:0] s2_txc, s2_txs, s2_tyc, s2_tys;
  logic [MPROD_BITS-1:0]       s2_wc, s2_ws, s2_hc, s2_hs;
  logic [MPROD_BITS-1:0]       s2_hxc, s2_hxs, s2_hyc, s2_hys;
  logic                        s2_sneg, s2_cneg;
  logic signed [OFS_BITS-1:0]  s2_tx, s2_ty;
  size_t                       s2_hx, s2_hy, s2_w, s2_h;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_txc  <= s1_tx * cm_s;
      s2_txs  <= s1_tx * sm_s;
      s2_tyc  <= s1_ty * cm_s;
      s2_tys  <= s1_ty * sm_s;
      s2_wc   <= s1_w * s1_cm;
      s2_ws   <= s1_w * s1_sm;
      s2_hc   <= s1_h * s1_cm;
      s2_hs   <= s1_h * s1_sm;
      s2_hxc  <= s1_hx * s1_cm;
      s2_hxs  <= s1_hx * s1_sm;
      s2_hyc  <= s1_hy * s1_cm;
      s2_hys  <= s1_hy * s1_sm;
      s2_sneg <= s1_sneg;
      s2_cneg <= s1_cneg;
      s2_tx   <= s1_tx;
      s2_ty   <= s1_ty;
      s2_hx   <= s1_hx;
      s2_hy   <= s1_hy;
      s2_w    <= s1_w;
      s2_h    <= s1_h;
    end
  end

  // stage 3: projection sums
  logic signed [PROD_BITS-1:0] txc, txs, tyc, tys;
  assign txc = s2_cneg ? -s2_txc : s2_txc;
  assign txs = s2_sneg ? -s2_txs : s2_txs;
  assign tyc = s2_cneg ? -s2_tyc : s2_tyc;
  assign tys = s2_sneg ? -s2_tys : s2_tys;

  logic signed [DIST_BITS-1:0] s3_d1, s3_d2;
  logic [RAD_BITS-1:0]         s3_r1, s3_r2, s3_r3, s3_r4;
  logic [OFS_BITS-1:0]         s3_ax, s3_ay;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d1 <= DIST_BITS'(txc) + DIST_BITS'(tys);
      s3_d2 <= DIST_BITS'(tyc) - DIST_BITS'(txs);
      s3_r1 <= (RAD_BITS'(s2_hx) << (TRIG_FRAC_BITS + 1))
             + RAD_BITS'(s2_wc) + RAD_BITS'(s2_hs);
      s3_r2 <= (RAD_BITS'(s2_hy) << (TRIG_FRAC_BITS + 1))
             + RAD_BITS'(s2_ws) + RAD_BITS'(s2_hc);
      s3_r3 <= (RAD_BITS'(s2_hxc) << 1) + (RAD_BITS'(s2_hys) << 1)
             + (RAD_BITS'(s2_w) << TRIG_FRAC_BITS);
      s3_r4 <= (RAD_BITS'(s2_hxs) << 1) + (RAD_BITS'(s2_hyc) << 1)
             + (RAD_BITS'(s2_h) << TRIG_FRAC_BITS);
      s3_ax <= s2_tx[OFS_BITS-1] ? OFS_BITS'(-s2_tx) : OFS_BITS'(s2_tx);
      s3_ay <= s2_ty[OFS_BITS-1] ? OFS_BITS'(-s2_ty) : OFS_BITS'(s2_ty);
    end
  end

  // stage 4: compare into the output register
  logic [DIST_BITS-1:0] a1, a2, a3, a4;
  logic                 hit;
  assign a1  = s3_d1[DIST_BITS-1] ? DIST_BITS'(-s3_d1) : DIST_BITS'(s3_d1);
  assign a2  = s3_d2[DIST_BITS-1] ? DIST_BITS'(-s3_d2) : DIST_BITS'(s3_d2);
  assign a3  = DIST_BITS'(s3_ax) << TRIG_FRAC_BITS;
  assign a4  = DIST_BITS'(s3_ay) << TRIG_FRAC_BITS;
  assign hit = !((a1 > DIST_BITS'(s3_r1)) || (a2 > DIST_BITS'(s3_r2))
              || (a3 > DIST_BITS'(s3_r3)) || (a4 > DIST_BITS'(s3_r4)));

  always_ff @(posedge clk) begin
    if (en) begin
      result.overlap <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      v1           <= query.valid;
      v2           <= v1;
      v3           <= v2;
      result.valid <= v3;
    end
  end

endmodule

// File: dv/obb_aabb_overlap_test_checker.sv
// Checker for the oriented box against axis-aligned box overlap test.
// Watches the query and result channels, predicts each overlap flag and compares.
// Depends on oat_pkg, oat_query_if and oat_result_if.
module obb_aabb_overlap_test_checker
  import oat_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  oat_query_if  query,
  oat_result_if result,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q = longint'(1) << TRIG_FRAC_BITS;

  longint sine_quarter [QSIZE+1];
  logic   overlap_expected [$];

  function automatic longint quarter_wave_entry(input longint unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned div;
    longint          acc;
    longint          r;
    x    = (k * HALF_PI_Q30) >> (ANGLE_BITS - 2);
    term = x;
    acc  = 0;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      if (n % 2 == 1) acc += longint'(term);
      else acc -= longint'(term);
      div  = longint'(2 * n) * longint'(2 * n + 1);
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / div;
    end
    if (acc < 0) acc = 0;
    r = (acc + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    if (r > ONE_Q) r = ONE_Q;
    return r;
  endfunction

  function automatic longint sine_at(input angle_t a);
    logic [1:0]            quad;
    logic [ANGLE_BITS-3:0] idx;
    longint                v;
    quad = a[ANGLE_BITS-1 -: 2];
    idx  = a[ANGLE_BITS-3:0];
    v    = quad[0] ? sine_quarter[QSIZE - int'(idx)] : sine_quarter[int'(idx)];
    return quad[1] ? -v : v;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic predict_overlap(
    input coord_t cx_f, input coord_t cy_f, input size_t hx_f, input size_t hy_f,
    input angle_t ang, input coord_t left_f, input coord_t top_f,
    input size_t w_f, input size_t h_f
  );
    longint cx, cy, hx2, hy2, lft, tp, w, h, sn, cs, tx, ty;
    logic   hit;
    cx  = longint'(cx_f);
    cy  = longint'(cy_f);
    hx2 = 2 * longint'(hx_f);
    hy2 = 2 * longint'(hy_f);
    lft = longint'(left_f);
    tp  = longint'(top_f);
    w   = longint'(w_f);
    h   = longint'(h_f);
    sn  = sine_at(ang);
    cs  = sine_at(angle_t'(ang + angle_t'(QSIZE)));
    tx  = 2 * lft + w - 2 * cx;
    ty  = 2 * tp + h - 2 * cy;
    hit = 1'b1;
    if (mag(tx * cs + ty * sn) > hx2 * ONE_Q + mag(w * cs) + mag(h * sn)) hit = 1'b0;
    if (mag(ty * cs - tx * sn) > hy2 * ONE_Q + mag(w * sn) + mag(h * cs)) hit = 1'b0;
    if (mag(tx) * ONE_Q > mag(cs) * hx2 + mag(sn) * hy2 + w * ONE_Q) hit = 1'b0;
    if (mag(ty) * ONE_Q > mag(sn) * hx2 + mag(cs) * hy2 + h * ONE_Q) hit = 1'b0;
    return hit;
  endfunction

  initial begin
    for (int k = 0; k <= QSIZE; k++) sine_quarter[k] = quarter_wave_entry(longint'(k));
  end

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      fail_count = 0;
      pending    = 0;
      overlap_expected.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (overlap_expected.size() == 0) begin
          $error("overlap: expected none pending, actual %0d", result.overlap);
          fail_count++;
        end else begin
          want = overlap_expected.pop_front();
          if (result.overlap !== want) begin
            $error("overlap: expected %0d, actual %0d", want, result.overlap);
            fail_count++;
          end
        end
      end
      if (query.valid && query.ready) begin
        overlap_expected = {overlap_expected, predict_overlap(
          query.box_center_x, query.box_center_y, query.box_half_x, query.box_half_y,
          query.box_angle, query.rect_left, query.rect_top,
          query.rect_width, query.rect_height)};
      end
      pending = overlap_expected.size();
    end
  end

endmodule

// File: dv/obb_aabb_overlap_test_test.sv
// Testbench top for the oriented box against axis-aligned box overlap test.
// Drives directed and random box pairs under several idling phases; the checker module
// predicts and compares. Depends on oat_pkg, the channel interfaces, design and checker.
module obb_aabb_overlap_test_test
  import oat_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    coord_t box_center_x;
    coord_t box_center_y;
    size_t  box_half_x;
    size_t  box_half_y;
    angle_t box_angle;
    coord_t rect_left;
    coord_t rect_top;
    size_t  rect_width;
    size_t  rect_height;
  } box_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   rx_hold_asks = 0;
  int   rx_hold_served = 0;

  oat_query_if  query_ch ();
  oat_result_if result_ch ();

  obb_aabb_overlap_test uut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch)
  );

  obb_aabb_overlap_test_checker chk (
    .clk        (clk),
    .rst        (rst),
    .query      (query_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_served != rx_hold_asks) begin
        rx_hold_served++;
        result_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic box_pair_t make_pair(
    input int cx, input int cy, input int hx, input int hy, input int ang,
    input int lft, input int tp, input int w, input int h
  );
    box_pair_t p;
    p.box_center_x = coord_t'(cx);
    p.box_center_y = coord_t'(cy);
    p.box_half_x   = size_t'(hx);
    p.box_half_y   = size_t'(hy);
    p.box_angle    = angle_t'(ang);
    p.rect_left    = coord_t'(lft);
    p.rect_top     = coord_t'(tp);
    p.rect_width   = size_t'(w);
    p.rect_height  = size_t'(h);
    return p;
  endfunction

  function automatic box_pair_t rand_pair();
    box_pair_t p;
    int        s;
    p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(3) != 0) begin
      // keep the boxes near each other at a random scale
      s = $urandom_range(18, 2);
      p.box_half_x  = size_t'($urandom_range((1 << s) - 1));
      p.box_half_y  = size_t'($urandom_range((1 << s) - 1));
      p.rect_width  = size_t'($urandom_range((1 << (s + 1)) - 1, 0));
      p.rect_height = size_t'($urandom_range((1 << (s + 1)) - 1, 0));
      p.rect_left   = p.box_center_x +
                      coord_t'(int'($urandom_range(1 << (s + 2))) - (1 << (s + 1)));
      p.rect_top    = p.box_center_y +
                      coord_t'(int'($urandom_range(1 << (s + 2))) - (1 << (s + 1)));
      if ($urandom_range(7) == 0) p.box_angle = angle_t'($urandom_range(3) * QSIZE);
    end
    return p;
  endfunction

  task automatic send_pair(input box_pair_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid        <= 1'b1;
    query_ch.box_center_x <= p.box_center_x;
    query_ch.box_center_y <= p.box_center_y;
    query_ch.box_half_x   <= p.box_half_x;
    query_ch.box_half_y   <= p.box_half_y;
    query_ch.box_angle    <= p.box_angle;
    query_ch.rect_left    <= p.rect_left;
    query_ch.rect_top     <= p.rect_top;
    query_ch.rect_width   <= p.rect_width;
    query_ch.rect_height  <= p.rect_height;
    do @(posedge clk); while (!query_ch.ready);
  endtask

  task automatic drain_results();
    query_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int n, input bit hold);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold) rx_hold_asks++;
    repeat (n) send_pair(rand_pair());
    drain_results();
  endtask

  initial begin
    box_pair_t directed [$];
    query_ch.valid        <= 1'b0;
    query_ch.box_center_x <= '0;
    query_ch.box_center_y <= '0;
    query_ch.box_half_x   <= '0;
    query_ch.box_half_y   <= '0;
    query_ch.box_angle    <= '0;
    query_ch.rect_left    <= '0;
    query_ch.rect_top     <= '0;
    query_ch.rect_width   <= '0;
    query_ch.rect_height  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    directed = {directed, make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, make_pair(0, 0, 256, 256, 0, 256, -256, 512, 512)};
    directed = {directed, make_pair(0, 0, 256, 256, 0, 257, -256, 512, 512)};
    directed = {directed, make_pair(0, 0, 256, 256, 0, -256, 256, 512, 512)};
    directed = {directed, make_pair(0, 0, 256, 256, 0, -256, 257, 512, 512)};
    directed = {directed, make_pair(0, 0, 256, 128, 1024, 128, -256, 512, 512)};
    directed = {directed, make_pair(0, 0, 256, 128, 1024, 129, -256, 512, 512)};
    directed = {directed, make_pair(0, 0, 256, 256, 2048, 256, -256, 512, 512)};
    directed = {directed, make_pair(0, 0, 128, 256, 3072, -256, 128, 512, 512)};
    directed = {directed, make_pair(0, 0, 1600, 160, 512, 1000, 1000, 200, 200)};
    directed = {directed, make_pair(0, 0, 1600, 160, 512, 1400, -1400, 200, 200)};
    directed = {directed, make_pair(50, -70, 900, 300, 4095, 800, -100, 64, 64)};
    directed = {directed, make_pair(-30, 40, 700, 200, 1, -900, 20, 32, 32)};
    directed = {directed, make_pair(10, 10, 500, 500, 1023, 480, 480, 100, 100)};
    directed = {directed, make_pair(10, 10, 500, 500, 1025, -600, -600, 90, 90)};
    directed = {directed, make_pair(-524288, -524288, 524287, 524287, 4095,
                                    524287, 524287, 524287, 524287)};
    directed = {directed, make_pair(524287, 524287, 0, 0, 0, -524288, -524288, 0, 0)};
    directed = {directed, make_pair(-524288, 524287, 524287, 0, 2047,
                                    524287, -524288, 524287, 0)};
    directed = {directed, make_pair(524287, -524288, 0, 524287, 3000,
                                    -524288, 524287, 0, 524287)};
    directed = {directed, make_pair(100, 100, 0, 0, 0, 100, 100, 0, 0)};
    directed = {directed, make_pair(100, 100, 0, 0, 0, 101, 100, 0, 0)};
    directed = {directed, make_pair(100, 100, 0, 0, 700, 50, 50, 100, 100)};
    directed = {directed, make_pair(0, 0, 256, 256, 0, 256, 0, 0, 0)};
    directed = {directed, make_pair(0, 0, 256, 256, 0, 257, 0, 0, 0)};
    foreach (directed[i]) send_pair(directed[i]);
    drain_results();

    run_phase(0, 0, 240, 1'b1);
    run_phase(63, 0, 235, 1'b0);
    run_phase(0, 63, 235, 1'b0);
    run_phase(30, 30, 240, 1'b0);

    repeat (20) @(posedge clk);
    if (pending != 0) $error("overlap: expected results left over: %0d", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
